FILE: rtl/sec_pkg.sv
package sec_pkg;

    localparam int DEF_MAX_POINTS_PER_DIR = 256;
    localparam int DEF_MAX_ORDER          = 4;

    localparam int DIM_W       = 2;
    localparam int COUNT_W     = 9;
    localparam int ORDER_W     = 3;
    localparam int NODE_W      = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIMENSION_COUNT = 3'd0,
        CFG_COUNT_U         = 3'd1,
        CFG_COUNT_V         = 3'd2,
        CFG_COUNT_W         = 3'd3,
        CFG_ORDER_U         = 3'd4,
        CFG_ORDER_V         = 3'd5,
        CFG_ORDER_W         = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [DIM_W-1:0]   dimension_count;
        logic [COUNT_W-1:0] count_u;
        logic [COUNT_W-1:0] count_v;
        logic [COUNT_W-1:0] count_w;
        logic [ORDER_W-1:0] order_u;
        logic [ORDER_W-1:0] order_v;
        logic [ORDER_W-1:0] order_w;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP_A,
        ST_SETUP_B,
        ST_SETUP_C,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic setup_a;
        logic setup_b;
        logic setup_c;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic qualify;
        logic last;
    } t_status;

endpackage

FILE: rtl/sec_cfg_regs.sv
module sec_cfg_regs
    import sec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dimension_count <= DIM_W'(3);
            r_cfg.count_u         <= COUNT_W'(1);
            r_cfg.count_v         <= COUNT_W'(1);
            r_cfg.count_w         <= COUNT_W'(1);
            r_cfg.order_u         <= ORDER_W'(1);
            r_cfg.order_v         <= ORDER_W'(1);
            r_cfg.order_w         <= ORDER_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_DIMENSION_COUNT: r_cfg.dimension_count <= i_cfg_data[DIM_W-1:0];
                CFG_COUNT_U:         r_cfg.count_u         <= i_cfg_data[COUNT_W-1:0];
                CFG_COUNT_V:         r_cfg.count_v         <= i_cfg_data[COUNT_W-1:0];
                CFG_COUNT_W:         r_cfg.count_w         <= i_cfg_data[COUNT_W-1:0];
                CFG_ORDER_U:         r_cfg.order_u         <= i_cfg_data[ORDER_W-1:0];
                CFG_ORDER_V:         r_cfg.order_v         <= i_cfg_data[ORDER_W-1:0];
                CFG_ORDER_W:         r_cfg.order_w         <= i_cfg_data[ORDER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/sec_ctrl.sv
module sec_ctrl
    import sec_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.qualify) begin
                        n_state = ST_SETUP_A;
                    end
                end
            end
            ST_SETUP_A: begin
                o_cmd.setup_a = 1'b1;
                n_state       = ST_SETUP_B;
            end
            ST_SETUP_B: begin
                o_cmd.setup_b = 1'b1;
                n_state       = ST_SETUP_C;
            end
            ST_SETUP_C: begin
                o_cmd.setup_c = 1'b1;
                n_state       = ST_EMIT;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/sec_datapath.sv
module sec_datapath
    import sec_pkg::*;
#(
    parameter int MAX_POINTS_PER_DIR = DEF_MAX_POINTS_PER_DIR,
    parameter int MAX_ORDER          = DEF_MAX_ORDER
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_span_u_nonempty,
    input  logic              i_span_v_nonempty,
    input  logic              i_span_w_nonempty,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic [NODE_W-1:0] o_node_number
);

    localparam int PW = $clog2(MAX_POINTS_PER_DIR);
    localparam int CW = $clog2(MAX_POINTS_PER_DIR + 1);
    localparam int OW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER + 1) : 1;
    localparam int JW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    function automatic logic [CW-1:0] f_count(input logic [COUNT_W-1:0] c);
        logic [31:0] x;
        x = 32'(c);
        if (x == 32'd0) begin
            x = 32'd1;
        end else if (x > 32'(MAX_POINTS_PER_DIR)) begin
            x = 32'(MAX_POINTS_PER_DIR);
        end
        return CW'(x);
    endfunction

    function automatic logic [OW-1:0] f_order(input logic [ORDER_W-1:0] p);
        logic [31:0] x;
        x = 32'(p);
        if (x == 32'd0) begin
            x = 32'd1;
        end else if (x > 32'(MAX_ORDER)) begin
            x = 32'(MAX_ORDER);
        end
        return OW'(x);
    endfunction

    logic              dim_ge2;
    logic              dim_ge3;
    logic [CW-1:0]     cu;
    logic [CW-1:0]     cv;
    logic [CW-1:0]     cw;
    logic [OW-1:0]     pu;
    logic [OW-1:0]     pv;
    logic [OW-1:0]     pw;
    logic [JW-1:0]     pu_m1;
    logic [JW-1:0]     pv_m1;
    logic [JW-1:0]     pw_m1;
    logic              fv;
    logic              fw;
    logic              u_wrap;
    logic              v_wrap;
    logic              w_wrap;
    logic [NODE_W-1:0] row_next;

    logic [PW-1:0]     r_pos_u;
    logic [PW-1:0]     r_pos_v;
    logic [PW-1:0]     r_pos_w;
    logic [NODE_W-1:0] r_running;
    logic [NODE_W-1:0] r_run_cap;
    logic [NODE_W-1:0] r_plane;
    logic [NODE_W-1:0] r_offv;
    logic [NODE_W-1:0] r_pstep;
    logic [NODE_W-1:0] r_plane_base;
    logic [NODE_W-1:0] r_row_base;
    logic [NODE_W-1:0] r_node;
    logic [JW-1:0]     r_j1;
    logic [JW-1:0]     r_j2;
    logic [JW-1:0]     r_j3;

    always_comb begin
        dim_ge2 = (i_cfg.dimension_count >= DIM_W'(2));
        dim_ge3 = (i_cfg.dimension_count == DIM_W'(3));
        cu      = f_count(i_cfg.count_u);
        cv      = dim_ge2 ? f_count(i_cfg.count_v) : CW'(1);
        cw      = dim_ge3 ? f_count(i_cfg.count_w) : CW'(1);
        pu      = f_order(i_cfg.order_u);
        pv      = dim_ge2 ? f_order(i_cfg.order_v) : OW'(1);
        pw      = dim_ge3 ? f_order(i_cfg.order_w) : OW'(1);
        pu_m1   = JW'(32'(pu) - 32'd1);
        pv_m1   = JW'(32'(pv) - 32'd1);
        pw_m1   = JW'(32'(pw) - 32'd1);
        fv      = dim_ge2 ? i_span_v_nonempty : 1'b1;
        fw      = dim_ge3 ? i_span_w_nonempty : 1'b1;
        u_wrap  = (32'(r_pos_u) + 32'd1) >= 32'(cu);
        v_wrap  = (32'(r_pos_v) + 32'd1) >= 32'(cv);
        w_wrap  = (32'(r_pos_w) + 32'd1) >= 32'(cw);
        o_status.qualify = ((32'(r_pos_u) + 32'd1) >= 32'(pu))
                        && ((32'(r_pos_v) + 32'd1) >= 32'(pv))
                        && ((32'(r_pos_w) + 32'd1) >= 32'(pw))
                        && i_span_u_nonempty && fv && fw;
        o_status.last = (r_j1 == '0) && (r_j2 == '0) && (r_j3 == '0);
        row_next = r_plane_base + r_pstep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_u   <= '0;
            r_pos_v   <= '0;
            r_pos_w   <= '0;
            r_running <= '0;
        end else if (i_cmd.capture) begin
            r_running <= r_running + NODE_W'(1);
            if (u_wrap) begin
                r_pos_u <= '0;
                if (v_wrap) begin
                    r_pos_v <= '0;
                    if (w_wrap) begin
                        r_pos_w   <= '0;
                        r_running <= '0;
                    end else begin
                        r_pos_w <= r_pos_w + PW'(1);
                    end
                end else begin
                    r_pos_v <= r_pos_v + PW'(1);
                end
            end else begin
                r_pos_u <= r_pos_u + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_run_cap <= r_running;
        end
        if (i_cmd.setup_a) begin
            r_plane <= NODE_W'(32'(cu) * 32'(cv));
            r_offv  <= NODE_W'(32'(cu) * 32'(pv_m1));
        end
        if (i_cmd.setup_b) begin
            r_plane_base <= r_run_cap - NODE_W'(r_plane * NODE_W'(pw_m1));
            r_pstep      <= r_plane - r_offv;
        end
        if (i_cmd.setup_c) begin
            r_row_base <= r_plane_base - r_offv;
            r_node     <= r_plane_base - r_offv - NODE_W'(pu_m1);
            r_j1       <= pu_m1;
            r_j2       <= pv_m1;
            r_j3       <= pw_m1;
        end
        if (i_cmd.step) begin
            if (r_j1 != '0) begin
                r_j1   <= r_j1 - JW'(1);
                r_node <= r_node + NODE_W'(1);
            end else if (r_j2 != '0) begin
                r_j2       <= r_j2 - JW'(1);
                r_j1       <= pu_m1;
                r_row_base <= r_row_base + NODE_W'(cu);
                r_node     <= r_row_base + NODE_W'(cu) - NODE_W'(pu_m1);
            end else if (r_j3 != '0) begin
                r_j3         <= r_j3 - JW'(1);
                r_j2         <= pv_m1;
                r_j1         <= pu_m1;
                r_plane_base <= r_plane_base + r_plane;
                r_row_base   <= row_next;
                r_node       <= row_next - NODE_W'(pu_m1);
            end
        end
    end

    assign o_node_number = r_node;

endmodule

FILE: rtl/spline_element_connectivity.sv
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   i_span_u/v/w_nonempty
// output    out        o_out_valid / i_out_stall o_node_number, o_element_end
// config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// A point that closes no element is taken and the block stays idle. A point that
// closes an element is transferred, passes the three setup steps A, B and C in the
// datapath, then emits order_u*order_v*order_w node numbers, one per transfer.
// Reset clears the point counters and loads the default configuration.
// A stall on the output holds the current node number; no new point is taken
// until the last node number of the element has been transferred.
module spline_element_connectivity
    import sec_pkg::*;
#(
    parameter int MAX_POINTS_PER_DIR = DEF_MAX_POINTS_PER_DIR,
    parameter int MAX_ORDER          = DEF_MAX_ORDER
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_span_u_nonempty,
    input  logic                   i_span_v_nonempty,
    input  logic                   i_span_w_nonempty,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [NODE_W-1:0]      o_node_number,
    output logic                   o_element_end
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    sec_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sec_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sec_datapath #(
        .MAX_POINTS_PER_DIR (MAX_POINTS_PER_DIR),
        .MAX_ORDER          (MAX_ORDER)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_span_u_nonempty (i_span_u_nonempty),
        .i_span_v_nonempty (i_span_v_nonempty),
        .i_span_w_nonempty (i_span_w_nonempty),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_node_number     (o_node_number)
    );

    assign o_element_end = status.last;

endmodule
